// ----- src/csrsp_pkg.sv -----
// Shared types, constants and codes of the CSR sparsity builder.
package csrsp_pkg;

   localparam int MaxDofsDefault        = 256;
   localparam int MaxCellsDefault       = 64;
   localparam int MaxDofsPerCellDefault = 8;

   localparam int OpWidth     = 3;
   localparam int DofWidth    = 8;
   localparam int IndexWidth  = 12;
   localparam int DataWidth   = 13;
   localparam int StatusWidth = 2;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 9;

   localparam logic [OpWidth-1:0] OP_LOAD     = 3'd0;
   localparam logic [OpWidth-1:0] OP_BUILD    = 3'd1;
   localparam logic [OpWidth-1:0] OP_READ_PTR = 3'd2;
   localparam logic [OpWidth-1:0] OP_READ_COL = 3'd3;
   localparam logic [OpWidth-1:0] OP_CLEAR    = 3'd4;

   localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] ST_RANGE     = 2'd1;
   localparam logic [StatusWidth-1:0] ST_LOAD      = 2'd2;
   localparam logic [StatusWidth-1:0] ST_NOT_BUILT = 2'd3;

   localparam logic [CsrAddrWidth-1:0] REG_NUM_DOFS      = 2'd0;
   localparam logic [CsrAddrWidth-1:0] REG_NUM_CELLS     = 2'd1;
   localparam logic [CsrAddrWidth-1:0] REG_DOFS_PER_CELL = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_START,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_CELL_MARK,
      ST_SCAN,
      ST_ROW_END,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic accept;       // latch request, do load, clear or read op
      logic row_init;     // store row pointer, reset cell counter
      logic cell_rd;      // issue reads of one cell entry
      logic cell_chk;     // compare entry against row
      logic cell_mark;    // mark entry
      logic scan;         // scan one mark
      logic row_next;     // advance row
      logic finish;       // write last pointer, set built
      logic out_load;     // load result register
   } cmd_type;

   typedef struct packed {
      logic req_build;
      logic rows_done;
      logic cells_done;
      logic entry_done;
      logic entry_last;
      logic hit;
      logic scan_done;
   } stat_type;

endpackage

// ----- src/csrsp_if.sv -----
// Valid/ready channel interfaces for request, response and register writes.
interface csrsp_req_if;
   logic                              valid;
   logic                              ready;
   logic [csrsp_pkg::OpWidth-1:0]     op;
   logic [csrsp_pkg::DofWidth-1:0]    dof_value;
   logic [csrsp_pkg::IndexWidth-1:0]  index;
   modport source (output valid, op, dof_value, index, input ready);
   modport sink   (input valid, op, dof_value, index, output ready);
endinterface

interface csrsp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [csrsp_pkg::DataWidth-1:0]   data;
   logic [csrsp_pkg::StatusWidth-1:0] status;
   modport source (output valid, data, status, input ready);
   modport sink   (input valid, data, status, output ready);
endinterface

interface csrsp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [csrsp_pkg::CsrAddrWidth-1:0] index;
   logic [csrsp_pkg::CsrDataWidth-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/csrsp_ctrl.sv -----
// Controller state machine for request handling and the build walk.
module csrsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_free,
   input  csrsp_pkg::stat_type  stat,
   output csrsp_pkg::cmd_type   cmd,
   output logic                 idle
);
   csrsp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csrsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csrsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = stat.req_build ? csrsp_pkg::ST_ROW_START : csrsp_pkg::ST_RESPOND;
            end
         end
         csrsp_pkg::ST_ROW_START: begin
            state_in = stat.rows_done ? csrsp_pkg::ST_FINISH : csrsp_pkg::ST_CELL_RD;
         end
         csrsp_pkg::ST_CELL_RD: begin
            state_in = stat.cells_done ? csrsp_pkg::ST_SCAN : csrsp_pkg::ST_CELL_CHK;
         end
         csrsp_pkg::ST_CELL_CHK: begin
            if (stat.hit) begin
               state_in = csrsp_pkg::ST_CELL_MARK;
            end else if (stat.entry_last) begin
               state_in = csrsp_pkg::ST_CELL_RD;
            end
         end
         csrsp_pkg::ST_CELL_MARK: begin
            if (stat.entry_done) begin
               state_in = csrsp_pkg::ST_CELL_RD;
            end
         end
         csrsp_pkg::ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = csrsp_pkg::ST_ROW_END;
            end
         end
         csrsp_pkg::ST_ROW_END: state_in = csrsp_pkg::ST_ROW_START;
         csrsp_pkg::ST_FINISH:  state_in = csrsp_pkg::ST_RESPOND;
         csrsp_pkg::ST_RESPOND: begin
            if (rsp_free) begin
               state_in = csrsp_pkg::ST_IDLE;
            end
         end
         default: state_in = csrsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      unique case (state_ff)
         csrsp_pkg::ST_IDLE: begin
            idle       = 1'b1;
            cmd.accept = req_fire;
         end
         csrsp_pkg::ST_ROW_START: cmd.row_init  = !stat.rows_done;
         csrsp_pkg::ST_CELL_RD:   cmd.cell_rd   = !stat.cells_done;
         csrsp_pkg::ST_CELL_CHK:  cmd.cell_chk  = 1'b1;
         csrsp_pkg::ST_CELL_MARK: cmd.cell_mark = 1'b1;
         csrsp_pkg::ST_SCAN:      cmd.scan      = 1'b1;
         csrsp_pkg::ST_ROW_END:   cmd.row_next  = 1'b1;
         csrsp_pkg::ST_FINISH:    cmd.finish    = 1'b1;
         csrsp_pkg::ST_RESPOND:   cmd.out_load  = rsp_free;
         default: cmd = '0;
      endcase
   end
endmodule

// ----- src/csrsp_dp.sv -----
// Datapath: stores, counters, marks and result formation.
module csrsp_dp #(
   parameter int MAX_DOFS          = csrsp_pkg::MaxDofsDefault,
   parameter int MAX_CELLS         = csrsp_pkg::MaxCellsDefault,
   parameter int MAX_DOFS_PER_CELL = csrsp_pkg::MaxDofsPerCellDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  csrsp_pkg::cmd_type                   cmd,
   output csrsp_pkg::stat_type                  stat,
   input  logic [csrsp_pkg::OpWidth-1:0]        in_op,
   input  logic [csrsp_pkg::DofWidth-1:0]       in_dof,
   input  logic [csrsp_pkg::IndexWidth-1:0]     in_index,
   input  logic                                 csr_we,
   input  logic [csrsp_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [csrsp_pkg::CsrDataWidth-1:0]   csr_data,
   output logic [csrsp_pkg::DataWidth-1:0]      out_data,
   output logic [csrsp_pkg::StatusWidth-1:0]    out_status
);
   localparam int ConnDepth = MAX_CELLS * MAX_DOFS_PER_CELL;
   localparam int ColDepth  = ConnDepth * MAX_DOFS_PER_CELL;
   localparam int DofsCap   = (MAX_DOFS < 256) ? MAX_DOFS : 256;
   localparam int CellsCap  = (MAX_CELLS < 64) ? MAX_CELLS : 64;
   localparam int DpcCap    = (MAX_DOFS_PER_CELL < 8) ? MAX_DOFS_PER_CELL : 8;
   localparam int CAW  = $clog2(ConnDepth + 1);
   localparam int CA   = (ConnDepth > 1) ? $clog2(ConnDepth) : 1;
   localparam int RW   = $clog2(DofsCap + 1);
   localparam int RA   = $clog2(DofsCap + 1);
   localparam int MA   = (DofsCap > 1) ? $clog2(DofsCap) : 1;
   localparam int TW   = $clog2(ColDepth + 1);
   localparam int KA   = (ColDepth > 1) ? $clog2(ColDepth) : 1;
   localparam int NCW  = $clog2(CellsCap + 1);
   localparam int DPW  = $clog2(DpcCap + 1);
   localparam int DW   = csrsp_pkg::DataWidth;

   logic [7:0]    conn_mem [ConnDepth];
   logic [DW-1:0] ptr_mem  [DofsCap + 1];
   logic [7:0]    col_mem  [ColDepth];
   logic [DofsCap-1:0] mark_ff;

   logic [RW-1:0]  num_dofs_ff;
   logic [NCW-1:0] num_cells_ff;
   logic [DPW-1:0] dpc_ff;
   logic [CAW-1:0] load_count_ff;
   logic [DPW-1:0] fill_phase_ff;
   logic [TW-1:0]  total_ff;
   logic           built_ff;

   logic [csrsp_pkg::OpWidth-1:0]    op_ff;
   logic [DW-1:0]                    rdata_ff;
   logic [csrsp_pkg::StatusWidth-1:0] rstat_ff;

   logic [RW-1:0]  row_ff;
   logic [CAW-1:0] base_ff, cells_end_ff;
   logic [DPW-1:0] ent_ff;
   logic [RW-1:0]  scan_ff;
   logic [7:0]     conn_q;

   logic [CAW-1:0] cap_w;
   logic [CAW-1:0] cells_end_w;
   logic [CAW-1:0] conn_raddr;
   logic           dof_ok, load_ok;

   assign cap_w = CAW'(num_cells_ff) * CAW'(dpc_ff);
   assign dof_ok  = 32'(in_dof) < 32'(num_dofs_ff);
   assign load_ok = (load_count_ff < cap_w) && (load_count_ff < CAW'(ConnDepth)) && dof_ok;
   // Whole cells only: drop the entries of a trailing incomplete cell.
   assign cells_end_w = load_count_ff - CAW'(fill_phase_ff);
   assign conn_raddr  = base_ff + CAW'(ent_ff);

   assign stat.req_build  = (in_op == csrsp_pkg::OP_BUILD);
   assign stat.rows_done  = (row_ff == num_dofs_ff);
   assign stat.cells_done = (base_ff == cells_end_ff);
   assign stat.hit        = (32'(conn_q) == 32'(row_ff));
   assign stat.entry_last = (ent_ff == dpc_ff);
   assign stat.entry_done = (ent_ff == dpc_ff);
   assign stat.scan_done  = (scan_ff == num_dofs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dofs_ff   <= RW'(DofsCap);
         num_cells_ff  <= NCW'(CellsCap);
         dpc_ff        <= DPW'(DpcCap);
         load_count_ff <= '0;
         fill_phase_ff <= '0;
         total_ff      <= '0;
         built_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               csrsp_pkg::REG_NUM_DOFS: begin
                  num_dofs_ff <= (csr_data == '0) ? RW'(1) :
                     (32'(csr_data) > DofsCap) ? RW'(DofsCap) : RW'(csr_data);
               end
               csrsp_pkg::REG_NUM_CELLS: begin
                  num_cells_ff <= (csr_data == '0) ? NCW'(1) :
                     (32'(csr_data) > CellsCap) ? NCW'(CellsCap) : NCW'(csr_data);
               end
               csrsp_pkg::REG_DOFS_PER_CELL: begin
                  dpc_ff <= (csr_data == '0) ? DPW'(1) :
                     (32'(csr_data) > DpcCap) ? DPW'(DpcCap) : DPW'(csr_data);
               end
               default: ;
            endcase
            if (csr_addr <= csrsp_pkg::REG_DOFS_PER_CELL) begin
               load_count_ff <= '0;
               fill_phase_ff <= '0;
               built_ff      <= 1'b0;
            end
         end
         if (cmd.accept) begin
            if (in_op == csrsp_pkg::OP_LOAD && load_ok) begin
               load_count_ff <= load_count_ff + CAW'(1);
               // Track the position inside the cell being loaded.
               fill_phase_ff <= (fill_phase_ff + DPW'(1) == dpc_ff) ? '0 :
                                fill_phase_ff + DPW'(1);
            end
            if (in_op == csrsp_pkg::OP_CLEAR) begin
               load_count_ff <= '0;
               fill_phase_ff <= '0;
            end
            if (in_op == csrsp_pkg::OP_BUILD) begin
               total_ff <= '0;
            end
         end
         if (cmd.scan && scan_ff != num_dofs_ff && mark_ff[scan_ff[MA-1:0]]
             && total_ff < TW'(ColDepth)) begin
            total_ff <= total_ff + TW'(1);
         end
         if (cmd.finish) begin
            built_ff <= 1'b1;
         end
      end
   end

   // Connectivity memory, one write port and one read port.
   always_ff @(posedge clock) begin
      if (cmd.accept && in_op == csrsp_pkg::OP_LOAD && load_ok) begin
         conn_mem[load_count_ff[CA-1:0]] <= in_dof;
      end
      conn_q <= conn_mem[conn_raddr[CA-1:0]];
   end

   // Build walk counters and row marks.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= in_op;
         row_ff       <= '0;
         cells_end_ff <= cells_end_w;
      end
      if (cmd.row_init) begin
         base_ff <= '0;
         ent_ff  <= '0;
         mark_ff <= '0;
         scan_ff <= '0;
      end
      if (cmd.cell_rd) begin
         ent_ff <= ent_ff + DPW'(1);
      end
      if (cmd.cell_chk) begin
         if (stat.hit) begin
            ent_ff <= '0;
         end else if (stat.entry_last) begin
            ent_ff  <= '0;
            base_ff <= base_ff + CAW'(dpc_ff);
         end else begin
            ent_ff <= ent_ff + DPW'(1);
         end
      end
      if (cmd.cell_mark) begin
         if (ent_ff != '0 && 32'(conn_q) < 32'(num_dofs_ff)) begin
            mark_ff[conn_q[MA-1:0]] <= 1'b1;
         end
         if (stat.entry_done) begin
            ent_ff  <= '0;
            base_ff <= base_ff + CAW'(dpc_ff);
         end else begin
            ent_ff <= ent_ff + DPW'(1);
         end
      end
      if (cmd.scan && !stat.scan_done) begin
         scan_ff <= scan_ff + RW'(1);
      end
      if (cmd.row_next) begin
         row_ff <= row_ff + RW'(1);
      end
   end

   // Row pointer and column memories; reads are issued with the accepted item.
   always_ff @(posedge clock) begin
      if (cmd.row_init) begin
         ptr_mem[row_ff[RA-1:0]] <= DW'(total_ff);
      end
      if (cmd.finish) begin
         ptr_mem[num_dofs_ff[RA-1:0]] <= DW'(total_ff);
      end
      if (cmd.scan && scan_ff != num_dofs_ff && mark_ff[scan_ff[MA-1:0]]
          && total_ff < TW'(ColDepth)) begin
         col_mem[total_ff[KA-1:0]] <= 8'(scan_ff);
      end
      if (cmd.accept) begin
         rdata_ff <= '0;
         if (in_op == csrsp_pkg::OP_READ_PTR) begin
            rdata_ff <= ptr_mem[in_index[RA-1:0]];
         end else if (in_op == csrsp_pkg::OP_READ_COL) begin
            rdata_ff <= DW'(col_mem[in_index[KA-1:0]]);
         end
      end
   end

   // Status, formed at accept from state before the operation.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rstat_ff <= csrsp_pkg::ST_OK;
         case (in_op)
            csrsp_pkg::OP_LOAD: begin
               if (!load_ok) rstat_ff <= csrsp_pkg::ST_LOAD;
            end
            csrsp_pkg::OP_READ_PTR: begin
               if (!built_ff) rstat_ff <= csrsp_pkg::ST_NOT_BUILT;
               else if (32'(in_index) > 32'(num_dofs_ff)) rstat_ff <= csrsp_pkg::ST_RANGE;
            end
            csrsp_pkg::OP_READ_COL: begin
               if (!built_ff) rstat_ff <= csrsp_pkg::ST_NOT_BUILT;
               else if (32'(in_index) >= 32'(total_ff) || 32'(in_index) >= ColDepth)
                  rstat_ff <= csrsp_pkg::ST_RANGE;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_status = rstat_ff;
      out_data   = '0;
      if (op_ff == csrsp_pkg::OP_BUILD) begin
         out_data = DW'(total_ff);
      end else if ((op_ff == csrsp_pkg::OP_READ_PTR || op_ff == csrsp_pkg::OP_READ_COL)
                   && rstat_ff == csrsp_pkg::ST_OK) begin
         out_data = rdata_ff;
      end
   end
endmodule

// ----- src/csr_sparsity_from_cell_dofs.sv -----
// Top level of the CSR sparsity pattern builder.
//
//  channel | dir | fields                      | notes
//  req_    | in  | op, dof_value, index        | one item, one result
//  rsp_    | out | data, status                | held until taken
//  csr_    | in  | index, wdata                | write while idle only
//
// Load, clear and read items: accept with the memory read,
// load the output register, hand the result over.
// Build time per row is set by the single connectivity memory read port
// and the one-mark-per-cycle scan.
// Reset is synchronous; all stores stay undefined until written.
// A stalled rsp_ holds the result and the request side stays not ready.
module csr_sparsity_from_cell_dofs #(
   parameter int MAX_DOFS          = csrsp_pkg::MaxDofsDefault,
   parameter int MAX_CELLS         = csrsp_pkg::MaxCellsDefault,
   parameter int MAX_DOFS_PER_CELL = csrsp_pkg::MaxDofsPerCellDefault
) (
   input logic          clock,
   input logic          reset,
   csrsp_req_if.sink    req_,
   csrsp_rsp_if.source  rsp_,
   csrsp_csr_if.sink    csr_
);
   csrsp_pkg::cmd_type  cmd;
   csrsp_pkg::stat_type stat;
   logic idle, req_fire, rsp_valid_ff;
   logic [csrsp_pkg::DataWidth-1:0]   dp_data, data_ff;
   logic [csrsp_pkg::StatusWidth-1:0] dp_status, status_ff;

   // Accept an item only when idle; hold off while a result waits.
   assign req_.ready = idle && !rsp_valid_ff;
   assign req_fire   = req_.valid && req_.ready;
   assign csr_.ready = 1'b1;

   csrsp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_free(!rsp_valid_ff || rsp_.ready), .stat(stat), .cmd(cmd), .idle(idle)
   );

   csrsp_dp #(
      .MAX_DOFS(MAX_DOFS), .MAX_CELLS(MAX_CELLS), .MAX_DOFS_PER_CELL(MAX_DOFS_PER_CELL)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_op(req_.op), .in_dof(req_.dof_value), .in_index(req_.index),
      .csr_we(csr_.valid), .csr_addr(csr_.index), .csr_data(csr_.wdata),
      .out_data(dp_data), .out_status(dp_status)
   );

   // Output register: load on respond, drop valid when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         data_ff   <= dp_data;
         status_ff <= dp_status;
      end
   end

   assign rsp_.valid  = rsp_valid_ff;
   assign rsp_.data   = data_ff;
   assign rsp_.status = status_ff;
endmodule

// ----- src/csrsp_checker.sv -----
// Port-level checker for the CSR sparsity builder, bound to the top level.
module csrsp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [csrsp_pkg::DataWidth-1:0]   rsp_data,
   input logic [csrsp_pkg::StatusWidth-1:0] rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
      else $error("response changed while stalled");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result shown one cycle after accept");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind csr_sparsity_from_cell_dofs csrsp_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_.valid), .req_ready(req_.ready),
   .rsp_valid(rsp_.valid), .rsp_ready(rsp_.ready),
   .rsp_data(rsp_.data), .rsp_status(rsp_.status)
);
